// File: sv/pbp_pkg.sv
// Shared types and constants for the perceptron branch predictor.
// Holds the controller state encoding and the command/status structs; no dependencies.
package pbp_pkg;

  // Default sizing of the predictor.
  localparam int ROW_COUNT_DEF      = 256;
  localparam int HISTORY_LENGTH_DEF = 32;
  localparam int WEIGHT_BITS_DEF    = 8;

  // Fixed field widths.
  localparam int PC_W   = 32;
  localparam int VADR_W = PC_W - 2;
  localparam int THR_W  = 10;
  localparam int CONF_W = 14;

  localparam logic [THR_W-1:0] THR_RESET = 10'd75;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_READ,
    ST_SUM1,
    ST_SUM2,
    ST_UPDATE
  } pbp_state_t;

  typedef struct packed {
    logic clear;    // write a zero row and advance the clear pointer
    logic capture;  // latch the incoming branch
    logic mul;      // reciprocal multiply for the row index
    logic modr;     // remainder correction, latch the row index
    logic rd;       // read the selected row
    logic sum1;     // first adder-tree level
    logic sum2;     // second adder-tree level
    logic update;   // write back, shift history, load the result
  } pbp_cmd_t;

  typedef struct packed {
    logic clear_last;  // clear pointer on the last row
    logic out_free;    // result register can take a new transaction
  } pbp_status_t;

endpackage

// File: sv/pbp_ctrl.sv
// Sequencer for the perceptron branch predictor.
// Depends on pbp_pkg for the state type and the command/status structs.
module pbp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  pbp_pkg::pbp_status_t status,
  output pbp_pkg::pbp_cmd_t    cmd,
  output logic                in_stall
);

  pbp_pkg::pbp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbp_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      pbp_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = pbp_pkg::ST_IDLE;
        end
      end
      pbp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = pbp_pkg::ST_MUL;
        end
      end
      pbp_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = pbp_pkg::ST_MOD;
      end
      pbp_pkg::ST_MOD: begin
        cmd.modr  = 1'b1;
        state_nxt = pbp_pkg::ST_READ;
      end
      pbp_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = pbp_pkg::ST_SUM1;
      end
      pbp_pkg::ST_SUM1: begin
        cmd.sum1  = 1'b1;
        state_nxt = pbp_pkg::ST_SUM2;
      end
      pbp_pkg::ST_SUM2: begin
        cmd.sum2  = 1'b1;
        state_nxt = pbp_pkg::ST_UPDATE;
      end
      pbp_pkg::ST_UPDATE: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = pbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pbp_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: sv/pbp_datapath.sv
// Datapath of the perceptron branch predictor: row index, weight memory,
// adder tree, training, history and result register. Depends on pbp_pkg.
module pbp_datapath #(
  parameter int ROW_COUNT      = pbp_pkg::ROW_COUNT_DEF,
  parameter int HISTORY_LENGTH = pbp_pkg::HISTORY_LENGTH_DEF,
  parameter int WEIGHT_BITS    = pbp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pbp_pkg::pbp_cmd_t                cmd,
  output pbp_pkg::pbp_status_t             status,
  input  logic [pbp_pkg::PC_W-1:0]         in_pc,
  input  logic                             in_outcome,
  input  logic                             cfg_we,
  input  logic [pbp_pkg::THR_W-1:0]        cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_predict_taken,
  output logic signed [pbp_pkg::CONF_W-1:0] out_confidence_sum
);

  localparam int H        = HISTORY_LENGTH;
  localparam int W        = WEIGHT_BITS;
  localparam int ROW_LEN  = H + 1;
  localparam int ROW_BITS = ROW_LEN * W;
  localparam int IDX_W    = $clog2(ROW_COUNT);
  localparam int N_W      = IDX_W + 1;
  localparam int VW       = pbp_pkg::VADR_W;
  localparam int SUM_W    = W + $clog2(ROW_LEN) + 1;
  localparam int CMP_W    = (SUM_W > pbp_pkg::THR_W) ? SUM_W : pbp_pkg::THR_W;
  localparam int EXT_W    = (SUM_W > pbp_pkg::CONF_W) ? SUM_W : pbp_pkg::CONF_W;
  localparam int GRP      = 8;
  localparam int NG       = (ROW_LEN + GRP - 1) / GRP;

  // Row index = vaddr mod ROW_COUNT via q = (vaddr * RECIP) >> DIV_SH, exact for 30-bit vaddr.
  localparam int          DIV_SH  = VW + IDX_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << DIV_SH) + 64'(ROW_COUNT) - 64'd1) / 64'(ROW_COUNT);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [N_W-1:0] NCONST = N_W'(ROW_COUNT);
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ROW_COUNT - 1);

  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] CONF_HI = EXT_W'(8191);
  localparam logic signed [EXT_W-1:0] CONF_LO = -EXT_W'(8192);

  logic [ROW_BITS-1:0] mem [ROW_COUNT];

  logic [pbp_pkg::THR_W-1:0] thr_r;
  logic [IDX_W-1:0]          clr_r;
  logic [VW-1:0]             vaddr_r;
  logic                      outcome_r;
  logic [VW+31:0]            prod_r;
  logic [IDX_W-1:0]          row_r;
  logic [ROW_BITS-1:0]       rd_r;
  logic signed [SUM_W-1:0]   part_r [NG];
  logic signed [SUM_W-1:0]   sum_r;
  logic [H-1:0]              hist_r;
  logic                      out_valid_r;
  logic                      out_pred_r;
  logic signed [pbp_pkg::CONF_W-1:0] out_conf_r;

  logic [VW-1:0]             quot;
  logic [VW-1:0]             rem;
  logic signed [SUM_W-1:0]   term [ROW_LEN];
  logic signed [SUM_W-1:0]   part_nxt [NG];
  logic signed [SUM_W-1:0]   sum_nxt;
  logic [SUM_W-1:0]          mag;
  logic                      pred;
  logic                      train;
  logic [ROW_BITS-1:0]       row_new;
  logic signed [EXT_W-1:0]   sum_ext;
  logic signed [pbp_pkg::CONF_W-1:0] conf_sat;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_addr;
  logic [ROW_BITS-1:0]       mem_wdata;

  assign status.clear_last = (clr_r == LAST_ROW);
  assign status.out_free   = !out_valid_r || !out_stall;

  // Index arithmetic.
  assign quot = VW'(prod_r >> DIV_SH);
  assign rem  = vaddr_r - VW'(quot * NCONST);

  // Signed terms: bias adds directly, weight i pairs with history bit i-1.
  always_comb begin
    logic signed [W-1:0] w;
    for (int i = 0; i < ROW_LEN; i++) begin
      w = $signed(rd_r[i*W +: W]);
      if (i == 0 || hist_r[(i == 0) ? 0 : i-1]) begin
        term[i] = SUM_W'(w);
      end else begin
        term[i] = -SUM_W'(w);
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g*GRP + k < ROW_LEN) begin
          acc = acc + term[(g*GRP + k < ROW_LEN) ? g*GRP + k : 0];
        end
      end
      part_nxt[g] = acc;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    acc = '0;
    for (int g = 0; g < NG; g++) begin
      acc = acc + part_r[g];
    end
    sum_nxt = acc;
  end

  // Decision and training.
  assign mag   = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign pred  = !sum_r[SUM_W-1] && (sum_r != '0);
  assign train = (pred != outcome_r) || (CMP_W'(mag) <= CMP_W'(thr_r));

  always_comb begin
    logic signed [W-1:0] w;
    logic                inc;
    for (int i = 0; i < ROW_LEN; i++) begin
      w   = $signed(rd_r[i*W +: W]);
      inc = (i == 0) ? outcome_r : (outcome_r == hist_r[(i == 0) ? 0 : i-1]);
      if (!train) begin
        row_new[i*W +: W] = w;
      end else if (inc) begin
        row_new[i*W +: W] = (w == W_MAX) ? w : w + W'(1);
      end else begin
        row_new[i*W +: W] = (w == W_MIN) ? w : w - W'(1);
      end
    end
  end

  // Clamp the reported sum to the output field.
  assign sum_ext  = EXT_W'(sum_r);
  assign conf_sat = (sum_ext > CONF_HI) ? pbp_pkg::CONF_W'(CONF_HI) :
                    (sum_ext < CONF_LO) ? pbp_pkg::CONF_W'(CONF_LO) :
                    pbp_pkg::CONF_W'(sum_ext);

  // Weight memory: one write port, one registered read port.
  assign mem_we    = cmd.clear || cmd.update;
  assign mem_addr  = cmd.clear ? clr_r : row_r;
  assign mem_wdata = cmd.clear ? '0 : row_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_r <= mem[row_r];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= pbp_pkg::THR_RESET;
      clr_r       <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if (cmd.update) begin
        hist_r <= H'({hist_r, outcome_r});
      end
      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vaddr_r   <= in_pc[pbp_pkg::PC_W-1:2];
      outcome_r <= in_outcome;
    end
    if (cmd.mul) begin
      prod_r <= (VW+32)'(vaddr_r) * (VW+32)'(RECIP);
    end
    if (cmd.modr) begin
      row_r <= rem[IDX_W-1:0];
    end
    if (cmd.sum1) begin
      for (int g = 0; g < NG; g++) begin
        part_r[g] <= part_nxt[g];
      end
    end
    if (cmd.sum2) begin
      sum_r <= sum_nxt;
    end
    if (cmd.update) begin
      out_pred_r <= pred;
      out_conf_r <= conf_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_predict_taken  = out_pred_r;
  assign out_confidence_sum = out_conf_r;

endmodule

// File: sv/perceptron_branch_predictor.sv
// Perceptron branch predictor, global history. A new branch is taken only after
// the previous one is written back, as the sequencer walks index multiply,
// remainder, row read, two adder-tree levels and write-back through the
// weight-memory write port; write-back waits while the output is stalled.
// Reset: synchronous active-low; history clears and a clearing pass zeroes the
// weight memory, one row a cycle, with input stalled.
module perceptron_branch_predictor #(
  parameter int ROW_COUNT      = pbp_pkg::ROW_COUNT_DEF,
  parameter int HISTORY_LENGTH = pbp_pkg::HISTORY_LENGTH_DEF,
  parameter int WEIGHT_BITS    = pbp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // branch input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pbp_pkg::PC_W-1:0]          in_pc,
  input  logic                              in_outcome,
  // prediction result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_predict_taken,
  output logic signed [pbp_pkg::CONF_W-1:0] out_confidence_sum,
  // training threshold register
  input  logic                              cfg_we,
  input  logic [pbp_pkg::THR_W-1:0]         cfg_wdata
);

  // Command and status between the sequencer and the datapath.
  pbp_pkg::pbp_cmd_t    cmd;
  pbp_pkg::pbp_status_t status;

  // The sequencer opens the input only when idle; every later step of a
  // transaction is one command pulse, and write-back waits on the result register.
  pbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // The datapath owns the weight memory, history, threshold and result register.
  // The result register frees the input side: a new transaction is taken while
  // a finished result still waits downstream.
  pbp_datapath #(
    .ROW_COUNT      (ROW_COUNT),
    .HISTORY_LENGTH (HISTORY_LENGTH),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_pc              (in_pc),
    .in_outcome         (in_outcome),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_predict_taken  (out_predict_taken),
    .out_confidence_sum (out_confidence_sum)
  );

endmodule
